@@ rtl/fcbg_pkg.sv @@
// shared constants and types for the four-corner bilinear color gradient
`timescale 1ns / 1ps

package fcbg_pkg;

    // largest grid edge in cells
    localparam int MAX_GRID_DIM = 64;

    localparam int DIM_W     = 7;   // grid size register width
    localparam int IDX_W     = 6;   // cell row / column width
    localparam int COLOR_W   = 32;
    localparam int CHAN_W    = 8;
    localparam int N_CHAN    = 3;   // blue, green, red
    localparam int WGT_W     = 2 * IDX_W;        // corner weight and divisor
    localparam int ACC_W     = CHAN_W + WGT_W;   // weighted channel sum
    localparam int DIV_STEPS = CHAN_W;           // one quotient bit per stage
    localparam int CFG_IDX_W = 3;

    // pipeline: input, weights, products, sums, then one stage per quotient bit
    localparam int PIPE_STAGES = 4 + DIV_STEPS;

    localparam logic [CHAN_W-1:0] ALPHA_BYTE = 8'hFF;

    localparam logic [DIM_W-1:0]   RST_COLUMNS = 7'd5;
    localparam logic [DIM_W-1:0]   RST_ROWS    = 7'd5;
    localparam logic [COLOR_W-1:0] RST_UL      = 32'hFFFF_FFFF;
    localparam logic [COLOR_W-1:0] RST_UR      = 32'h0000_FFFF;
    localparam logic [COLOR_W-1:0] RST_LL      = 32'h00FF_00FF;
    localparam logic [COLOR_W-1:0] RST_LR      = 32'hFF00_00FF;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GRID_COLUMNS = 3'd0,
        CFG_GRID_ROWS    = 3'd1,
        CFG_UL_COLOR     = 3'd2,
        CFG_UR_COLOR     = 3'd3,
        CFG_LL_COLOR     = 3'd4,
        CFG_LR_COLOR     = 3'd5
    } t_cfg_reg;

endpackage

@@ rtl/four_corner_bilinear_color_gradient.sv @@
// 4-corner bilinear rgb blend on a configurable grid; one cell per clock unless stalled
`timescale 1ns / 1ps
// pipeline of 12 register stages: input, weights, products, sums, then eight divider stages
//   of one quotient bit each
// throughput: one item per cycle while the output takes them; each stage holds only while
//   the stages after it are full and the output is stalled, so bubbles are squeezed out
// reset: synchronous active-low; clears all stage valid bits and loads the register reset
//   values (5 x 5 grid and the default corner colors)

module four_corner_bilinear_color_gradient (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [5:0]  i_cell_row,
    input  logic [5:0]  i_cell_column,

    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_cell_rgba,
    output logic        o_outside_grid,

    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    localparam int NS = fcbg_pkg::PIPE_STAGES;
    localparam int ND = fcbg_pkg::DIV_STEPS;
    localparam int NC = fcbg_pkg::N_CHAN;

    // configuration
    logic [fcbg_pkg::DIM_W-1:0]   r_grid_columns;
    logic [fcbg_pkg::DIM_W-1:0]   r_grid_rows;
    logic [fcbg_pkg::COLOR_W-1:0] r_ul_color;
    logic [fcbg_pkg::COLOR_W-1:0] r_ur_color;
    logic [fcbg_pkg::COLOR_W-1:0] r_ll_color;
    logic [fcbg_pkg::COLOR_W-1:0] r_lr_color;

    logic [fcbg_pkg::IDX_W-1:0] n_w;    // columns - 1 after clamping
    logic [fcbg_pkg::IDX_W-1:0] n_h;    // rows - 1 after clamping
    logic [fcbg_pkg::WGT_W-1:0] r_den;

    // pipeline control
    logic [NS:1] r_vld;
    logic [NS:1] n_en;

    // stage 1
    logic [fcbg_pkg::IDX_W-1:0] r_row;
    logic [fcbg_pkg::IDX_W-1:0] r_col;
    logic [fcbg_pkg::IDX_W-1:0] r_h_minus_r;
    logic [fcbg_pkg::IDX_W-1:0] r_w_minus_c;
    // outside flag travels with the item through every stage
    logic [NS:1] r_oob;

    // stage 2: corner weights ul, ur, ll, lr
    logic [fcbg_pkg::WGT_W-1:0] r_wgt [0:3];

    // stage 3: channel times weight
    logic [fcbg_pkg::ACC_W-1:0] r_prod [0:NC-1][0:3];

    // stage 4 onward: partial remainder and quotient per channel
    logic [fcbg_pkg::ACC_W-1:0]  r_rem [0:ND][0:NC-1];
    logic [fcbg_pkg::CHAN_W-1:0] r_quo [0:ND][0:NC-1];
    logic [fcbg_pkg::ACC_W-1:0]  n_dsh [0:ND-1];

    // clamp grid size to 2..max and take the edge lengths
    always_comb begin
        logic [fcbg_pkg::DIM_W-1:0] v_cols;
        logic [fcbg_pkg::DIM_W-1:0] v_rows;
        v_cols = r_grid_columns;
        v_rows = r_grid_rows;
        if (v_cols < fcbg_pkg::DIM_W'(2)) begin
            v_cols = fcbg_pkg::DIM_W'(2);
        end else if (v_cols > fcbg_pkg::DIM_W'(fcbg_pkg::MAX_GRID_DIM)) begin
            v_cols = fcbg_pkg::DIM_W'(fcbg_pkg::MAX_GRID_DIM);
        end
        if (v_rows < fcbg_pkg::DIM_W'(2)) begin
            v_rows = fcbg_pkg::DIM_W'(2);
        end else if (v_rows > fcbg_pkg::DIM_W'(fcbg_pkg::MAX_GRID_DIM)) begin
            v_rows = fcbg_pkg::DIM_W'(fcbg_pkg::MAX_GRID_DIM);
        end
        n_w = fcbg_pkg::IDX_W'(v_cols - fcbg_pkg::DIM_W'(1));
        n_h = fcbg_pkg::IDX_W'(v_rows - fcbg_pkg::DIM_W'(1));
    end

    // a stage may load when it is empty or the stage after it moves on
    always_comb begin
        n_en[NS] = !r_vld[NS] || i_out_ready;
        for (int k = NS - 1; k >= 1; k--) begin
            n_en[k] = !r_vld[k] || n_en[k+1];
        end
    end

    // divisor aligned to each quotient bit, msb first
    always_comb begin
        for (int k = 0; k < ND; k++) begin
            n_dsh[k] = fcbg_pkg::ACC_W'(r_den) << (ND - 1 - k);
        end
    end

    assign o_in_ready  = n_en[1];
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_columns <= fcbg_pkg::RST_COLUMNS;
            r_grid_rows    <= fcbg_pkg::RST_ROWS;
            r_ul_color     <= fcbg_pkg::RST_UL;
            r_ur_color     <= fcbg_pkg::RST_UR;
            r_ll_color     <= fcbg_pkg::RST_LL;
            r_lr_color     <= fcbg_pkg::RST_LR;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                fcbg_pkg::CFG_GRID_COLUMNS: r_grid_columns <= i_cfg_data[fcbg_pkg::DIM_W-1:0];
                fcbg_pkg::CFG_GRID_ROWS:    r_grid_rows    <= i_cfg_data[fcbg_pkg::DIM_W-1:0];
                fcbg_pkg::CFG_UL_COLOR:     r_ul_color     <= i_cfg_data;
                fcbg_pkg::CFG_UR_COLOR:     r_ur_color     <= i_cfg_data;
                fcbg_pkg::CFG_LL_COLOR:     r_ll_color     <= i_cfg_data;
                fcbg_pkg::CFG_LR_COLOR:     r_lr_color     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // the divisor is registered but first used in the divider stages, so its lag is harmless
    always_ff @(posedge i_clk) begin
        r_den <= {{fcbg_pkg::IDX_W{1'b0}}, n_w} * {{fcbg_pkg::IDX_W{1'b0}}, n_h};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (n_en[1]) begin
                r_vld[1] <= i_in_valid;
            end
            for (int k = 2; k <= NS; k++) begin
                if (n_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        // stage 1
        if (n_en[1]) begin
            r_row       <= i_cell_row;
            r_col       <= i_cell_column;
            r_h_minus_r <= n_h - i_cell_row;
            r_w_minus_c <= n_w - i_cell_column;
            r_oob[1]    <= (i_cell_row > n_h) || (i_cell_column > n_w);
        end
        for (int k = 2; k <= NS; k++) begin
            if (n_en[k]) begin
                r_oob[k] <= r_oob[k-1];
            end
        end

        // stage 2
        if (n_en[2]) begin
            r_wgt[0] <= {{fcbg_pkg::IDX_W{1'b0}}, r_h_minus_r}
                      * {{fcbg_pkg::IDX_W{1'b0}}, r_w_minus_c};
            r_wgt[1] <= {{fcbg_pkg::IDX_W{1'b0}}, r_h_minus_r}
                      * {{fcbg_pkg::IDX_W{1'b0}}, r_col};
            r_wgt[2] <= {{fcbg_pkg::IDX_W{1'b0}}, r_row}
                      * {{fcbg_pkg::IDX_W{1'b0}}, r_w_minus_c};
            r_wgt[3] <= {{fcbg_pkg::IDX_W{1'b0}}, r_row}
                      * {{fcbg_pkg::IDX_W{1'b0}}, r_col};
        end

        // stage 3: channel 0 is blue at bits 15:8, up to red at 31:24
        if (n_en[3]) begin
            for (int ch = 0; ch < NC; ch++) begin
                r_prod[ch][0] <= fcbg_pkg::ACC_W'(r_ul_color[8*ch+15 -: 8])
                               * fcbg_pkg::ACC_W'(r_wgt[0]);
                r_prod[ch][1] <= fcbg_pkg::ACC_W'(r_ur_color[8*ch+15 -: 8])
                               * fcbg_pkg::ACC_W'(r_wgt[1]);
                r_prod[ch][2] <= fcbg_pkg::ACC_W'(r_ll_color[8*ch+15 -: 8])
                               * fcbg_pkg::ACC_W'(r_wgt[2]);
                r_prod[ch][3] <= fcbg_pkg::ACC_W'(r_lr_color[8*ch+15 -: 8])
                               * fcbg_pkg::ACC_W'(r_wgt[3]);
            end
        end

        // stage 4: sum is at most 255 * den, so it fits and the quotient is 8 bits
        if (n_en[4]) begin
            for (int ch = 0; ch < NC; ch++) begin
                r_rem[0][ch] <= r_prod[ch][0] + r_prod[ch][1]
                              + r_prod[ch][2] + r_prod[ch][3];
                r_quo[0][ch] <= '0;
            end
        end

        // restoring divide, one quotient bit per stage
        for (int k = 0; k < ND; k++) begin
            if (n_en[5+k]) begin
                for (int ch = 0; ch < NC; ch++) begin
                    if (r_rem[k][ch] >= n_dsh[k]) begin
                        r_rem[k+1][ch] <= r_rem[k][ch] - n_dsh[k];
                        r_quo[k+1][ch] <= {r_quo[k][ch][fcbg_pkg::CHAN_W-2:0], 1'b1};
                    end else begin
                        r_rem[k+1][ch] <= r_rem[k][ch];
                        r_quo[k+1][ch] <= {r_quo[k][ch][fcbg_pkg::CHAN_W-2:0], 1'b0};
                    end
                end
            end
        end
    end

    assign o_out_valid    = r_vld[NS];
    assign o_outside_grid = r_oob[NS];
    assign o_cell_rgba    = r_oob[NS] ? '0
                          : {r_quo[ND][2], r_quo[ND][1], r_quo[ND][0], fcbg_pkg::ALPHA_BYTE};

`ifndef ASSERT_OFF
    // a cell inside the grid always carries an opaque alpha byte
    a_alpha_opaque: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_outside_grid |-> o_cell_rgba[7:0] == fcbg_pkg::ALPHA_BYTE)
        else $error("alpha byte not opaque");

    // outside cells give a zero color
    a_outside_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_outside_grid |-> o_cell_rgba == '0)
        else $error("outside cell color not zero");

    // the divide has finished: every remainder is below the divisor
    a_rem_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_outside_grid |->
            r_rem[ND][0] < fcbg_pkg::ACC_W'(r_den) && r_rem[ND][1] < fcbg_pkg::ACC_W'(r_den)
            && r_rem[ND][2] < fcbg_pkg::ACC_W'(r_den))
        else $error("divider remainder not below divisor");

    // input is refused only when every stage holds an item
    a_no_bubble_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> &r_vld)
        else $error("input stalled with an empty stage");

    // a stalled result stays in the output stage
    a_out_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_cell_rgba))
        else $error("stalled result lost");
`endif

endmodule

@@ bench/four_corner_bilinear_color_gradient_tb.sv @@
// self-checking bench for the four-corner bilinear gradient: random cells against a blend predictor
`timescale 1ns / 1ps

module four_corner_bilinear_color_gradient_tb;

    localparam int  TIMEOUT_NS   = 4_000_000;
    localparam int  HOLD_CYCLES  = 300;
    localparam int  ITEMS_PER_SET = 195;

    // indexes past the register list, writes there must be dropped
    localparam logic [fcbg_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [fcbg_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [fcbg_pkg::IDX_W-1:0] row;
        logic [fcbg_pkg::IDX_W-1:0] col;
    } t_grid_pos;

    typedef struct packed {
        logic [fcbg_pkg::COLOR_W-1:0] rgba;
        logic                         outside;
    } t_cell_color;

    logic               i_clk          = 1'b0;
    logic               i_rst_n        = 1'b0;
    logic               i_in_valid     = 1'b0;
    logic               o_in_ready;
    logic [5:0]         i_cell_row     = '0;
    logic [5:0]         i_cell_column  = '0;
    logic               o_out_valid;
    logic               i_out_ready    = 1'b0;
    logic [31:0]        o_cell_rgba;
    logic               o_outside_grid;
    logic               i_cfg_valid    = 1'b0;
    logic               o_cfg_ready;
    logic [2:0]         i_cfg_index    = '0;
    logic [31:0]        i_cfg_data     = '0;

    // predictor copy of the configuration
    logic [fcbg_pkg::DIM_W-1:0]   grid_cols_reg  = fcbg_pkg::RST_COLUMNS;
    logic [fcbg_pkg::DIM_W-1:0]   grid_rows_reg  = fcbg_pkg::RST_ROWS;
    logic [fcbg_pkg::COLOR_W-1:0] ul_reg         = fcbg_pkg::RST_UL;
    logic [fcbg_pkg::COLOR_W-1:0] ur_reg         = fcbg_pkg::RST_UR;
    logic [fcbg_pkg::COLOR_W-1:0] ll_reg         = fcbg_pkg::RST_LL;
    logic [fcbg_pkg::COLOR_W-1:0] lr_reg         = fcbg_pkg::RST_LR;

    t_grid_pos          pending_cells[$];
    t_cell_color        color_due[$];
    int                 cells_issued   = 0;
    int                 results_seen   = 0;
    int                 error_count    = 0;
    int                 send_idle_pct  = 0;
    int                 recv_stall_pct = 0;
    logic               hold_request   = 1'b0;
    int                 hold_left      = 0;

    four_corner_bilinear_color_gradient uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_cell_row     (i_cell_row),
        .i_cell_column  (i_cell_column),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_cell_rgba    (o_cell_rgba),
        .o_outside_grid (o_outside_grid),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    function automatic int clamp_dim(input logic [fcbg_pkg::DIM_W-1:0] v);
        if (v < 2) return 2;
        if (v > fcbg_pkg::MAX_GRID_DIM) return fcbg_pkg::MAX_GRID_DIM;
        return int'(v);
    endfunction

    function automatic t_cell_color blend_cell_color(input t_grid_pos pos);
        t_cell_color       res;
        longint unsigned   w, h, r, c, wa, wb, wc, wd, den, sum, v;
        int                cols, rows, sh;
        cols = clamp_dim(grid_cols_reg);
        rows = clamp_dim(grid_rows_reg);
        res.rgba = 32'h0;
        res.outside = 1'b0;
        if (pos.row >= rows || pos.col >= cols) begin
            res.outside = 1'b1;
            return res;
        end
        r = pos.row;
        c = pos.col;
        w = cols - 1;
        h = rows - 1;
        wa = (h - r) * (w - c);
        wb = (h - r) * c;
        wc = r * (w - c);
        wd = r * c;
        den = w * h;
        res.rgba[fcbg_pkg::CHAN_W-1:0] = fcbg_pkg::ALPHA_BYTE;
        for (int ch = 1; ch <= fcbg_pkg::N_CHAN; ch++) begin
            sh = ch * fcbg_pkg::CHAN_W;
            sum = ul_reg[sh +: fcbg_pkg::CHAN_W] * wa + ur_reg[sh +: fcbg_pkg::CHAN_W] * wb
                + ll_reg[sh +: fcbg_pkg::CHAN_W] * wc + lr_reg[sh +: fcbg_pkg::CHAN_W] * wd;
            v = sum / den;
            if (v > 255) v = 255;
            res.rgba[sh +: fcbg_pkg::CHAN_W] = v[fcbg_pkg::CHAN_W-1:0];
        end
        return res;
    endfunction

    function automatic void apply_cfg(input logic [fcbg_pkg::CFG_IDX_W-1:0] idx,
                                      input logic [fcbg_pkg::COLOR_W-1:0] data);
        case (idx)
            fcbg_pkg::CFG_GRID_COLUMNS: grid_cols_reg = data[fcbg_pkg::DIM_W-1:0];
            fcbg_pkg::CFG_GRID_ROWS:    grid_rows_reg = data[fcbg_pkg::DIM_W-1:0];
            fcbg_pkg::CFG_UL_COLOR:     ul_reg = data;
            fcbg_pkg::CFG_UR_COLOR:     ur_reg = data;
            fcbg_pkg::CFG_LL_COLOR:     ll_reg = data;
            fcbg_pkg::CFG_LR_COLOR:     lr_reg = data;
            default: ;
        endcase
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        error_count++;
    endtask

    task automatic write_cfg(input logic [fcbg_pkg::CFG_IDX_W-1:0] idx,
                             input logic [fcbg_pkg::COLOR_W-1:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        apply_cfg(idx, data);
    endtask

    task automatic set_grid(input logic [fcbg_pkg::DIM_W-1:0] cols,
                            input logic [fcbg_pkg::DIM_W-1:0] rows,
                            input logic [fcbg_pkg::COLOR_W-1:0] ul,
                            input logic [fcbg_pkg::COLOR_W-1:0] ur,
                            input logic [fcbg_pkg::COLOR_W-1:0] ll,
                            input logic [fcbg_pkg::COLOR_W-1:0] lr);
        // upper bits of the column size write may carry junk, the block keeps only 7 bits
        write_cfg(fcbg_pkg::CFG_GRID_COLUMNS,
                  {$urandom_range(0, 1) ? 25'h1FFFFFF : 25'h0, cols});
        write_cfg(fcbg_pkg::CFG_GRID_ROWS, {25'h0, rows});
        write_cfg(fcbg_pkg::CFG_UL_COLOR, ul);
        write_cfg(fcbg_pkg::CFG_UR_COLOR, ur);
        write_cfg(fcbg_pkg::CFG_LL_COLOR, ll);
        write_cfg(fcbg_pkg::CFG_LR_COLOR, lr);
        write_cfg($urandom_range(0, 1) ? CFG_SPARE_LO : CFG_SPARE_HI, $urandom);
    endtask

    task automatic queue_pos(input int row, input int col);
        t_grid_pos pos;
        pos.row = row[fcbg_pkg::IDX_W-1:0];
        pos.col = col[fcbg_pkg::IDX_W-1:0];
        pending_cells = {pending_cells, pos};
        cells_issued++;
    endtask

    task automatic queue_random_cells(input int n);
        int rows, cols;
        rows = clamp_dim(grid_rows_reg);
        cols = clamp_dim(grid_cols_reg);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 99) < 85)
                queue_pos($urandom_range(0, rows - 1), $urandom_range(0, cols - 1));
            else
                queue_pos($urandom_range(0, 63), $urandom_range(0, 63));
        end
    endtask

    task automatic wait_drained();
        while (results_seen != cells_issued) @(posedge i_clk);
        repeat (fcbg_pkg::PIPE_STAGES + 4) @(posedge i_clk);
    endtask

    task automatic set_pacing(input int phase);
        case (phase % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 60; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 60; end
            default: begin send_idle_pct = 13; recv_stall_pct = 13; end
        endcase
    endtask

    // input side
    always @(posedge i_clk) begin : drive_cells
        t_grid_pos pos;
        logic      taken;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            taken = i_in_valid && o_in_ready;
            if (taken) begin
                pos.row = i_cell_row;
                pos.col = i_cell_column;
                color_due = {color_due, blend_cell_color(pos)};
            end
            if (taken || !i_in_valid) begin
                if (pending_cells.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    pos = pending_cells.pop_front();
                    i_in_valid    <= 1'b1;
                    i_cell_row    <= pos.row;
                    i_cell_column <= pos.col;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off
    always @(posedge i_clk) begin
        if (hold_request) begin
            hold_left <= HOLD_CYCLES;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // output side
    always @(posedge i_clk) begin : check_colors
        t_cell_color want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                results_seen++;
                if (color_due.size() == 0) begin
                    report_mismatch($sformatf("unexpected item rgba %h outside %b",
                                              o_cell_rgba, o_outside_grid));
                end else begin
                    want = color_due.pop_front();
                    if (o_cell_rgba !== want.rgba)
                        report_mismatch($sformatf("cell_rgba %h, want %h",
                                                  o_cell_rgba, want.rgba));
                    if (o_outside_grid !== want.outside)
                        report_mismatch($sformatf("outside_grid %b, want %b",
                                                  o_outside_grid, want.outside));
                end
            end
            i_out_ready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    initial begin
        #(TIMEOUT_NS);
        $display("four_corner_bilinear_color_gradient_tb: FAIL");
        $finish;
    end

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset grid: corners, center, edges just past the grid, extreme indexes
        set_pacing(0);
        queue_pos(0, 0);   queue_pos(0, 4);   queue_pos(4, 0);   queue_pos(4, 4);
        queue_pos(2, 2);   queue_pos(1, 3);   queue_pos(4, 2);   queue_pos(5, 0);
        queue_pos(0, 5);   queue_pos(5, 5);   queue_pos(63, 63); queue_pos(63, 0);
        queue_pos(0, 63);  queue_pos(42, 21); queue_pos(21, 42);
        queue_random_cells(ITEMS_PER_SET);
        @(posedge i_clk);
        hold_request <= 1'b1;
        @(posedge i_clk);
        hold_request <= 1'b0;
        wait_drained();

        for (int phase = 1; phase < 10; phase++) begin
            case (phase)
                1: set_grid(7'd2, 7'd2, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0);
                2: set_grid(7'd64, 7'd64, $urandom, $urandom, $urandom, $urandom);
                3: set_grid(7'd0, 7'd1, $urandom, $urandom, $urandom, $urandom);
                4: set_grid(7'd127, 7'd65, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                            32'hFFFF_FFFF, 32'hFFFF_FFFF);
                5: set_grid(7'd2, 7'd64, $urandom, $urandom, $urandom, $urandom);
                6: set_grid(7'd64, 7'd2, 32'h0, 32'h0, 32'h0, 32'h0);
                default: set_grid(7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)),
                                  $urandom, $urandom, $urandom, $urandom);
            endcase
            set_pacing(phase);
            queue_random_cells(ITEMS_PER_SET);
            if (phase == 4 || phase == 8) begin
                @(posedge i_clk);
                hold_request <= 1'b1;
                @(posedge i_clk);
                hold_request <= 1'b0;
            end
            wait_drained();
        end

        if (color_due.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", color_due.size()));
        if (error_count == 0) begin
            $display("four_corner_bilinear_color_gradient_tb: PASS");
        end else begin
            $display("four_corner_bilinear_color_gradient_tb: FAIL");
        end
        $finish;
    end

endmodule
